/* rtl/keyframe_window_eviction_assert.svh */
// Assertion macros for the keyframe window eviction block.
`ifndef KEYFRAME_WINDOW_EVICTION_ASSERT_SVH
`define KEYFRAME_WINDOW_EVICTION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and idle in reset.
`define KWE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and idle in reset.
`define KWE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kwe_pkg.sv */
// Shared types and constants of the keyframe window eviction block.
`timescale 1ns / 1ps

package kwe_pkg;

  // Default window depth.
  localparam int unsigned NUM_SLOTS_DEF = 16;

  // Field widths.
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned LIMIT_W   = 4;
  localparam int unsigned THR_W     = 52;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Distance arithmetic widths: 25-bit difference, 49-bit square, 50-bit sum.
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned SQ_W   = 2 * POS_W + 1;
  localparam int unsigned DIST_W = SQ_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR     = 2'd1;

  // Configuration reset values.
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd7;
  localparam logic [THR_W-1:0]   THR_RST   = 52'd2621;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP_START,
    ST_LOOKUP_WAIT,
    ST_WRITE,
    ST_CHECK,
    ST_EVICT_START,
    ST_EVICT_WAIT,
    ST_FINISH
  } kwe_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_evict;
    logic write_slot;
    logic finish;
  } kwe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_busy;
    logic need_evict;
  } kwe_status_t;

endpackage

/* rtl/kwe_ctrl.sv */
// Controller state machine that sequences lookup, write, eviction scan and result.
`timescale 1ns / 1ps

module kwe_ctrl
  import kwe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_free_i,
  input  kwe_status_t status_i,
  output kwe_cmd_t    cmd_o
);

  kwe_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP_START;
      end
      ST_LOOKUP_START: state_d = ST_LOOKUP_WAIT;
      ST_LOOKUP_WAIT: begin
        if (!status_i.scan_busy) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = status_i.need_evict ? ST_EVICT_START : ST_FINISH;
      end
      ST_EVICT_START: state_d = ST_EVICT_WAIT;
      ST_EVICT_WAIT: begin
        if (!status_i.scan_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_LOOKUP_START: cmd_o.scan_start = 1'b1;
      ST_LOOKUP_WAIT:  ;
      ST_WRITE:        cmd_o.write_slot = 1'b1;
      ST_CHECK:        ;
      ST_EVICT_START: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_evict = 1'b1;
      end
      ST_EVICT_WAIT:   ;
      ST_FINISH:       cmd_o.finish = out_free_i;
      default:         ;
    endcase
  end

endmodule

/* rtl/kwe_datapath.sv */
// Datapath: slot memory, valid bits, window count and the distance scan pipeline.
`timescale 1ns / 1ps

module kwe_datapath
  import kwe_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kwe_cmd_t                cmd_i,
  output kwe_status_t             status_o,
  input  logic [KEY_W-1:0]        key_id_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic [LIMIT_W-1:0]      active_limit_i,
  input  logic [THR_W-1:0]        near_threshold_sq_i,
  output logic                    evicted_o,
  output logic [KEY_W-1:0]        evicted_id_o,
  output logic [CNT_OUT_W-1:0]    active_count_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned MW = KEY_W + 3 * POS_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  // Item being inserted.
  logic [KEY_W-1:0] key_q;
  logic [POS_W-1:0] px_q, py_q, pz_q;

  // Slot store and window state.
  logic [MW-1:0]        mem_q [NUM_SLOTS];
  logic [MW-1:0]        rd_q;
  logic [NUM_SLOTS-1:0] valid_q;
  logic [CW-1:0]        count_q;
  logic [SW-1:0]        newest_q;

  // Scan sequencing.
  logic          issue_q, mode_evict_q;
  logic [SW-1:0] idx_q;
  logic          p1_v_q;
  logic [SW-1:0] p1_idx_q;

  // Lookup results.
  logic          match_found_q, free_found_q;
  logic [SW-1:0] match_slot_q, free_slot_q;

  // Distance pipeline.
  logic              p2_v_q, p2_ok_q;
  logic [SW-1:0]     p2_idx_q;
  logic [KEY_W-1:0]  p2_key_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic              p3_v_q, p3_ok_q;
  logic [SW-1:0]     p3_idx_q;
  logic [KEY_W-1:0]  p3_key_q;
  logic [DIST_W-1:0] dist_q;

  // Nearest and farthest candidates.
  logic              cand_found_q;
  logic [SW-1:0]     near_slot_q, far_slot_q;
  logic [KEY_W-1:0]  near_key_q, far_key_q;
  logic [DIST_W-1:0] near_d_q, far_d_q;

  // Combinational helpers.
  logic [KEY_W-1:0]      rd_key;
  logic [POS_W-1:0]      rd_px, rd_py, rd_pz;
  logic                  rd_slot_valid;
  logic [DIFF_W-1:0]     dx, dy, dz, mx, my, mz;
  logic [2*DIFF_W-1:0]   prodx, prody, prodz;
  logic [DIST_W-1:0]     dist_d;
  logic [SW-1:0]         wr_slot;
  logic                  wr_new;
  logic                  near_pick;
  logic [SW-1:0]         victim;
  logic [KEY_W-1:0]      victim_key;
  logic [LW-1:0]         lim_raw, lim_eff;
  logic [CW-1:0]         cnt_after;
  logic [CW+CNT_OUT_W-1:0] cnt_wide;

  // Latch the item at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      key_q <= key_id_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pz_q  <= pos_z_i;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_slot) begin
      mem_q[wr_slot] <= {key_q, px_q, py_q, pz_q};
    end
    if (issue_q) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Unpack the read word.
  assign rd_key        = rd_q[MW-1 -: KEY_W];
  assign rd_px         = rd_q[3*POS_W-1 -: POS_W];
  assign rd_py         = rd_q[2*POS_W-1 -: POS_W];
  assign rd_pz         = rd_q[POS_W-1:0];
  assign rd_slot_valid = valid_q[p1_idx_q];

  // Slot that the item goes to: its own slot if the id is active, else the lowest free one.
  assign wr_slot = match_found_q ? match_slot_q : (free_found_q ? free_slot_q : '0);
  assign wr_new  = !match_found_q && free_found_q;

  // Absolute coordinate differences and their squares.
  always_comb begin
    dx    = {px_q[POS_W-1], px_q} - {rd_px[POS_W-1], rd_px};
    dy    = {py_q[POS_W-1], py_q} - {rd_py[POS_W-1], rd_py};
    dz    = {pz_q[POS_W-1], pz_q} - {rd_pz[POS_W-1], rd_pz};
    mx    = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
    my    = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
    mz    = dz[DIFF_W-1] ? (~dz + 1'b1) : dz;
    prodx = {{DIFF_W{1'b0}}, mx} * {{DIFF_W{1'b0}}, mx};
    prody = {{DIFF_W{1'b0}}, my} * {{DIFF_W{1'b0}}, my};
    prodz = {{DIFF_W{1'b0}}, mz} * {{DIFF_W{1'b0}}, mz};
  end

  // Squared distance from the three registered squares.
  assign dist_d = DIST_W'(sqx_q) + DIST_W'(sqy_q) + DIST_W'(sqz_q);

  // Victim choice: nearest when it lies below the threshold, else farthest.
  assign near_pick  = {{(THR_W-DIST_W){1'b0}}, near_d_q} < near_threshold_sq_i;
  assign victim     = near_pick ? near_slot_q : far_slot_q;
  assign victim_key = near_pick ? near_key_q : far_key_q;

  // Effective limit is capped so that a free slot always remains.
  always_comb begin
    lim_raw = LW'(active_limit_i);
    lim_eff = (lim_raw > LW'(NUM_SLOTS - 1)) ? LW'(NUM_SLOTS - 1) : lim_raw;
  end

  assign status_o.need_evict = LW'(count_q) > lim_eff;
  assign status_o.scan_busy  = issue_q | p1_v_q | p2_v_q | p3_v_q;

  // Result fields.
  assign cnt_after      = count_q - {{(CW-1){1'b0}}, cand_found_q};
  assign cnt_wide       = {{CNT_OUT_W{1'b0}}, cnt_after};
  assign active_count_o = cnt_wide[CNT_OUT_W-1:0];
  assign evicted_o      = cand_found_q;
  assign evicted_id_o   = cand_found_q ? victim_key : '0;

  // Scan address generator and first pipeline valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q      <= 1'b0;
      mode_evict_q <= 1'b0;
      idx_q        <= '0;
      p1_v_q       <= 1'b0;
      p1_idx_q     <= '0;
    end else begin
      p1_v_q   <= issue_q;
      p1_idx_q <= idx_q;
      if (cmd_i.scan_start) begin
        issue_q      <= 1'b1;
        mode_evict_q <= cmd_i.scan_evict;
        idx_q        <= '0;
      end else if (issue_q) begin
        if (idx_q == LAST_SLOT) begin
          issue_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Lookup of the id and of the lowest free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      match_slot_q  <= '0;
      free_slot_q   <= '0;
    end else if (cmd_i.load_item) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else if (p1_v_q && !mode_evict_q) begin
      if (rd_slot_valid && (rd_key == key_q) && !match_found_q) begin
        match_found_q <= 1'b1;
        match_slot_q  <= p1_idx_q;
      end
      if (!rd_slot_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_slot_q  <= p1_idx_q;
      end
    end
  end

  // Distance pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      p2_v_q <= p1_v_q && mode_evict_q;
      p3_v_q <= p2_v_q;
    end
  end

  // Distance pipeline payload.
  always_ff @(posedge clk_i) begin
    p2_ok_q  <= rd_slot_valid && (p1_idx_q != newest_q);
    p2_idx_q <= p1_idx_q;
    p2_key_q <= rd_key;
    sqx_q    <= prodx[SQ_W-1:0];
    sqy_q    <= prody[SQ_W-1:0];
    sqz_q    <= prodz[SQ_W-1:0];
    p3_ok_q  <= p2_ok_q;
    p3_idx_q <= p2_idx_q;
    p3_key_q <= p2_key_q;
    dist_q   <= dist_d;
  end

  // Running nearest and farthest; strict compares keep the lowest slot on ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_found_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      cand_found_q <= 1'b0;
    end else if (p3_v_q && p3_ok_q) begin
      cand_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_v_q && p3_ok_q) begin
      if (!cand_found_q || (dist_q > far_d_q)) begin
        far_d_q    <= dist_q;
        far_slot_q <= p3_idx_q;
        far_key_q  <= p3_key_q;
      end
      if (!cand_found_q || (dist_q < near_d_q)) begin
        near_d_q    <= dist_q;
        near_slot_q <= p3_idx_q;
        near_key_q  <= p3_key_q;
      end
    end
  end

  // Window state: insert on write, evict on finish.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      count_q  <= '0;
      newest_q <= '0;
    end else if (cmd_i.write_slot) begin
      valid_q[wr_slot] <= 1'b1;
      newest_q         <= wr_slot;
      if (wr_new) begin
        count_q <= count_q + 1'b1;
      end
    end else if (cmd_i.finish && cand_found_q) begin
      valid_q[victim] <= 1'b0;
      count_q         <= count_q - 1'b1;
    end
  end

endmodule

/* rtl/keyframe_window_eviction.sv */
// Top level of the keyframe window eviction block.
`timescale 1ns / 1ps
// Sliding window of active keyframes with distance-based eviction.
// Input channel (in_valid_i/in_ready_o) carries one keyframe item: an id and a
// Q15.8 position. The item overwrites the position of an active slot with the
// same id, or takes the lowest free slot. When the window then holds more than
// the active limit, the block evicts the nearest other keyframe if it lies
// below the distance threshold, else the farthest one.
// Output channel (out_valid_o/out_ready_i) returns one item per input item:
// the eviction flag, the evicted id and the active count.
// Configuration writes (cfg_valid_i, always ready) set the active limit and
// the squared distance threshold; they must be made by the user only while
// the block is idle, which the block itself does not enforce. Each item takes
// a sweep of the slot memory's single read port for the id lookup, the slot
// write and, with eviction, a second sweep for the distance scan.
// One item is in work at a time; the block is ready for the next item once
// the result sits in the output register, even if the receiver has not taken it yet.
// If the receiver stalls with a result still held, the next result waits in
// the finish step until the output register is free.
// Reset empties the window and restores the register defaults (limit 7,
// threshold 2621).

`include "keyframe_window_eviction_assert.svh"

module keyframe_window_eviction
  import kwe_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [KEY_W-1:0]        key_id_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    evicted_o,
  output logic [KEY_W-1:0]        evicted_id_o,
  output logic [CNT_OUT_W-1:0]    active_count_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [THR_W-1:0]        cfg_data_i
);

  logic [LIMIT_W-1:0]   active_limit_q;
  logic [THR_W-1:0]     near_thr_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 res_evicted;
  logic [KEY_W-1:0]     res_id;
  logic [CNT_OUT_W-1:0] res_count;
  logic                 evicted_q;
  logic [KEY_W-1:0]     evicted_id_q;
  logic [CNT_OUT_W-1:0] active_count_q;
  kwe_cmd_t             cmd;
  kwe_status_t          status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_limit_q <= LIMIT_RST;
      near_thr_q     <= THR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_LIMIT: active_limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_NEAR_THR:     near_thr_q     <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Controller.
  kwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  kwe_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .key_id_i            (key_id_i),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .pos_z_i             (pos_z_i),
    .active_limit_i      (active_limit_q),
    .near_threshold_sq_i (near_thr_q),
    .evicted_o           (res_evicted),
    .evicted_id_o        (res_id),
    .active_count_o      (res_count)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      evicted_q      <= res_evicted;
      evicted_id_q   <= res_id;
      active_count_q <= res_count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign evicted_o      = evicted_q;
  assign evicted_id_o   = evicted_id_q;
  assign active_count_o = active_count_q;

  // A result is loaded only into a free output register.
  `KWE_ASSERT_IMPL(a_load_when_free, cmd.finish, !out_valid_q || out_ready_i, "result overwrote a held item")
  // Input acceptance and result loading never coincide.
  `KWE_ASSERT_IMPL(a_no_accept_on_finish, in_valid_i && in_ready_o, !cmd.finish, "accept during finish")
  // One item in work at a time.
  `KWE_ASSERT_NEXT(a_one_in_work, in_valid_i && in_ready_o, !in_ready_o, "second item taken while busy")
  // No eviction means a zero id.
  `KWE_ASSERT_IMPL(a_zero_id, out_valid_o && !evicted_o, evicted_id_o == '0, "nonzero id without eviction")

endmodule

/* bench/keyframe_window_eviction_test.sv */
// Testbench for the keyframe window eviction block: directed and random inserts.
`timescale 1ns / 1ps

module keyframe_window_eviction_test;
  import kwe_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;

  // Expected result of one insert.
  typedef struct packed {
    logic                 evicted;
    logic [KEY_W-1:0]     id;
    logic [CNT_OUT_W-1:0] count;
  } eviction_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [KEY_W-1:0]        key_id_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic signed [POS_W-1:0] pos_z_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    evicted_o;
  logic [KEY_W-1:0]        evicted_id_o;
  logic [CNT_OUT_W-1:0]    active_count_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [THR_W-1:0]        cfg_data_i;

  // Shadow copy of the window and of the registers.
  logic                    window_valid [SLOTS];
  logic [KEY_W-1:0]        window_key   [SLOTS];
  logic signed [POS_W-1:0] window_x     [SLOTS];
  logic signed [POS_W-1:0] window_y     [SLOTS];
  logic signed [POS_W-1:0] window_z     [SLOTS];
  int                      window_count;
  logic [LIMIT_W-1:0]      window_limit;
  logic [THR_W-1:0]        near_thr;

  eviction_t               expected_evictions[$];
  eviction_t               head_result;
  int                      mismatch_count = 0;

  // Traffic shaping.
  bit                      steady_flow;
  int unsigned             burst_left;
  int unsigned             ready_run = 0;
  bit                      ready_level = 1'b1;
  logic [KEY_W-1:0]        last_key;
  logic [KEY_W-1:0]        key_pool [24];
  logic signed [POS_W-1:0] cluster_x, cluster_y, cluster_z;

  keyframe_window_eviction u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_id_i       (key_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .evicted_o      (evicted_o),
    .evicted_id_o   (evicted_id_o),
    .active_count_o (active_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Prints one line per mismatch and counts them all.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Exact squared distance between two positions in Q.16 square meters.
  function automatic longint unsigned squared_distance(
      input logic signed [POS_W-1:0] ax, input logic signed [POS_W-1:0] ay,
      input logic signed [POS_W-1:0] az, input logic signed [POS_W-1:0] bx,
      input logic signed [POS_W-1:0] by, input logic signed [POS_W-1:0] bz);
    longint dx, dy, dz;
    dx = longint'(ax);
    dx = dx - bx;
    dy = longint'(ay);
    dy = dy - by;
    dz = longint'(az);
    dz = dz - bz;
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Applies one insert to the shadow window and queues the expected result.
  task automatic predict_insert(input logic [KEY_W-1:0] key,
                                input logic signed [POS_W-1:0] x,
                                input logic signed [POS_W-1:0] y,
                                input logic signed [POS_W-1:0] z);
    int              slot;
    int              limit;
    int              near_slot, far_slot, victim;
    bit              found;
    longint unsigned sq_dist, near_d, far_d;
    eviction_t       result;
    slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && window_valid[i] && window_key[i] == key) slot = i;
    end
    // A new id takes the lowest free slot.
    if (slot < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !window_valid[i]) slot = i;
      end
      window_valid[slot] = 1'b1;
      window_key[slot]   = key;
      window_count++;
    end
    window_x[slot] = x;
    window_y[slot] = y;
    window_z[slot] = z;

    limit = (window_limit > SLOTS - 1) ? SLOTS - 1 : window_limit;
    result = '0;
    if (window_count > limit) begin
      // Scan the other active slots for the nearest and the farthest one.
      found = 1'b0;
      near_slot = 0;
      far_slot = 0;
      near_d = 0;
      far_d = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (window_valid[i] && i != slot) begin
          sq_dist = squared_distance(window_x[i], window_y[i], window_z[i], x, y, z);
          if (!found) begin
            found = 1'b1;
            near_slot = i;
            far_slot = i;
            near_d = sq_dist;
            far_d = sq_dist;
          end else begin
            if (sq_dist > far_d) begin
              far_d = sq_dist;
              far_slot = i;
            end
            if (sq_dist < near_d) begin
              near_d = sq_dist;
              near_slot = i;
            end
          end
        end
      end
      if (found) begin
        victim = (near_d < near_thr) ? near_slot : far_slot;
        window_valid[victim] = 1'b0;
        window_count--;
        result.evicted = 1'b1;
        result.id = window_key[victim];
      end
    end
    result.count = window_count[CNT_OUT_W-1:0];
    expected_evictions.push_back(result);
  endtask

  // Sends one keyframe item; valid stays high for a following item in a burst.
  task automatic send_keyframe(input logic [KEY_W-1:0] key,
                               input logic signed [POS_W-1:0] x,
                               input logic signed [POS_W-1:0] y,
                               input logic signed [POS_W-1:0] z);
    int unsigned gap;
    if (!steady_flow && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    key_id_i   <= key;
    pos_x_i    <= x;
    pos_y_i    <= y;
    pos_z_i    <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    last_key = key;
    predict_insert(key, x, y, z);
  endtask

  // Stops sending and waits until every pending result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_evictions.size() != 0) @(posedge clk_i);
  endtask

  // Writes both registers; upper data bits of the limit write are don't-care.
  task automatic write_config(input logic [LIMIT_W-1:0] limit,
                              input logic [THR_W-1:0] thr);
    logic [THR_W-1:0] limit_word;
    limit_word = THR_W'({$urandom, $urandom});
    limit_word[LIMIT_W-1:0] = limit;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ACTIVE_LIMIT;
    cfg_data_i  <= limit_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    window_limit = limit;
    cfg_index_i <= CFG_NEAR_THR;
    cfg_data_i  <= thr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    near_thr = thr;
    cfg_valid_i <= 1'b0;
  endtask

  // Random coordinate: mostly near the cluster center, sometimes anywhere.
  function automatic logic signed [POS_W-1:0] pick_coord(
      input logic signed [POS_W-1:0] center);
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      v = int'(center);
      v = v + $urandom_range(0, 160) - 80;
      return v[POS_W-1:0];
    end else if (sel < 9) begin
      v = $urandom;
      return v[POS_W-1:0];
    end
    case ($urandom_range(0, 3))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'sh000000;
      default: return 24'shFFFFFF;
    endcase
  endfunction

  // Random id: often the last one again, mostly from a small pool.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) return last_key;
    if (sel < 16) return key_pool[$urandom_range(0, 23)];
    return KEY_W'($urandom);
  endfunction

  // Fill the window with the reset limit; the overflow evicts the farthest.
  task automatic test_fill_window();
    logic [KEY_W-1:0] ids [8];
    ids = '{16'h0000, 16'hFFFF, 16'd3, 16'd200, 16'd4096, 16'd30000, 16'hAAAA,
            16'h5555};
    for (int i = 0; i < 8; i++) begin
      send_keyframe(ids[i], 24'(i * 1024), -24'(i * 512), 24'sd0);
    end
  endtask

  // Overwrite an active id, then insert a new id right next to another one.
  task automatic test_overwrite_and_near();
    send_keyframe(16'd3, 24'sd4100, -24'sd2040, 24'sd2);
    send_keyframe(16'd9, 24'sd3082, -24'sd1536, 24'sd0);
  endtask

  // Opposite corners of the position range give the largest distances.
  task automatic test_position_extremes();
    send_keyframe(16'd40000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_keyframe(16'd40001, 24'sh800000, 24'sh800000, 24'sh800000);
  endtask

  // All keyframes at one point: ties must go to the lowest slot.
  task automatic test_distance_ties();
    logic [KEY_W-1:0] active_ids[$];
    drain_results();
    write_config(4'd15, THR_RST);
    for (int i = 0; i < SLOTS; i++) begin
      if (window_valid[i]) active_ids.push_back(window_key[i]);
    end
    foreach (active_ids[i]) send_keyframe(active_ids[i], 24'sd1000, -24'sd2000, 24'sd300);
    // Zero threshold: equal farthest distances.
    drain_results();
    write_config(window_count[LIMIT_W-1:0], '0);
    send_keyframe(16'd100, 24'sd1000, -24'sd2000, 24'sd300);
    // Nearest distances all zero and below the threshold.
    drain_results();
    write_config(window_count[LIMIT_W-1:0], THR_RST);
    send_keyframe(16'd101, 24'sd1000, -24'sd2000, 24'sd300);
  endtask

  // A limit of zero, outside the nominal range, is used as it is.
  task automatic test_zero_limit();
    drain_results();
    write_config(4'd0, THR_RST);
    send_keyframe(16'd7, 24'sd0, 24'sd0, 24'sd0);
    send_keyframe(16'd7, 24'sd5, 24'sd5, 24'sd5);
  endtask

  // Random phases, each with its own register setting and traffic shape.
  task automatic test_random_traffic();
    logic [LIMIT_W-1:0] limit;
    logic [THR_W-1:0]   thr;
    for (int i = 0; i < 24; i++) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int phase = 0; phase < 16; phase++) begin
      drain_results();
      case (phase)
        0: begin
          limit = 4'd1;
          thr = '1;
        end
        1: begin
          limit = 4'd15;
          thr = '0;
        end
        2: begin
          limit = 4'd0;
          thr = THR_RST;
        end
        default: begin
          limit = LIMIT_W'($urandom_range(0, 15));
          case ($urandom_range(0, 4))
            0: thr = '0;
            1: thr = '1;
            2: thr = THR_RST;
            3: thr = THR_W'($urandom_range(0, 20000));
            default: thr = THR_W'({$urandom, $urandom});
          endcase
        end
      endcase
      write_config(limit, thr);
      steady_flow = (phase % 5 == 3);
      cluster_x = POS_W'($urandom_range(0, 1 << 23)) - 24'sh400000;
      cluster_y = POS_W'($urandom_range(0, 1 << 23)) - 24'sh400000;
      cluster_z = POS_W'($urandom_range(0, 1 << 23)) - 24'sh400000;
      repeat (100) begin
        send_keyframe(pick_key(), pick_coord(cluster_x), pick_coord(cluster_y),
                      pick_coord(cluster_z));
      end
    end
  endtask

  // Result checker: each taken item is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_evictions.size() == 0) begin
        report_mismatch("result with nothing pending, active_count", 64'(active_count_o),
                        64'(0));
      end else begin
        head_result = expected_evictions.pop_front();
        if (evicted_o !== head_result.evicted) begin
          report_mismatch("evicted", 64'(evicted_o), 64'(head_result.evicted));
        end
        if (evicted_id_o !== head_result.id) begin
          report_mismatch("evicted_id", 64'(evicted_id_o), 64'(head_result.id));
        end
        if (active_count_o !== head_result.count) begin
          report_mismatch("active_count", 64'(active_count_o), 64'(head_result.count));
        end
      end
    end
  end

  // Receiver: runs of ready and stall of random length, or always ready.
  always @(posedge clk_i) begin
    if (steady_flow) begin
      out_ready_i <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_level = ($urandom_range(0, 2) != 0);
        ready_run = ready_level ? $urandom_range(1, 20) : $urandom_range(1, 12);
      end
      ready_run--;
      out_ready_i <= ready_level;
    end
  end

  // Main sequence.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    key_id_i       = '0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_ACTIVE_LIMIT;
    cfg_data_i     = '0;
    steady_flow    = 1'b0;
    burst_left     = 0;
    last_key       = '0;
    for (int i = 0; i < SLOTS; i++) window_valid[i] = 1'b0;
    window_count = 0;
    window_limit = LIMIT_RST;
    near_thr     = THR_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_window();
    test_overwrite_and_near();
    test_position_extremes();
    test_distance_ties();
    test_zero_limit();
    test_random_traffic();

    // Let any stray result show up after the last expected one.
    drain_results();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/kwe_pkg.sv
rtl/kwe_ctrl.sv
rtl/kwe_datapath.sv
rtl/keyframe_window_eviction.sv
bench/keyframe_window_eviction_test.sv
